// ===== rtl/core/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg: shared types for the indexed min-heap queue
// Command codes, result status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package imhq_pkg;

	typedef enum logic [1:0] {
		CMD_INIT     = 2'd0,
		CMD_EXTRACT  = 2'd1,
		CMD_DECREASE = 2'd2,
		CMD_LOOKUP   = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	// one datapath operation per cycle
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DISPATCH,
		OP_FILL,
		OP_SEED,
		OP_SU_CHK,
		OP_SU_CMP,
		OP_SD_CHK,
		OP_SD_L,
		OP_SD_R,
		OP_SD_MOVE,
		OP_EX_ROOT,
		OP_EX_LAST,
		OP_MAP_CHK,
		OP_KEY_CHK,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic bad_id;
		logic fill_last;
		logic src_ok;
		logic at_root;
		logic up_swap;
		logic has_left;
		logic has_right;
		logic best_hit;
		logic map_hit;
		logic key_lower;
	} stat_t;

endpackage

// ===== rtl/core/imhq_in_if.sv =====
// ----------------------------------------------------------------------------
// imhq_in_if: command channel
// Valid/ready channel carrying one queue command.
// ----------------------------------------------------------------------------
interface imhq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [8:0]  node_id;
	logic [15:0] new_cost;

	modport source (output valid, cmd, node_id, new_cost, input ready);
	modport sink (input valid, cmd, node_id, new_cost, output ready);
endinterface

// ===== rtl/core/imhq_out_if.sv =====
// ----------------------------------------------------------------------------
// imhq_out_if: result channel
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
interface imhq_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  out_node;
	logic [15:0] out_cost;
	logic        in_heap;
	logic [1:0]  status;

	modport source (output valid, out_node, out_cost, in_heap, status, input ready);
	modport sink (input valid, out_node, out_cost, in_heap, status, output ready);
endinterface

// ===== rtl/core/imhq_ram.sv =====
// ----------------------------------------------------------------------------
// imhq_ram: simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module imhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/imhq_dp.sv =====
// ----------------------------------------------------------------------------
// imhq_dp: heap datapath
// Heap and position-map RAMs, the sifting entry, best-child and result regs.
// ----------------------------------------------------------------------------
module imhq_dp import imhq_pkg::*; #(
	parameter int NUM_NODES = 256,
	parameter int COST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output stat_t       stat,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic [1:0]  cmd,
	input  logic [8:0]  node_id,
	input  logic [15:0] new_cost,
	output logic [8:0]  out_node,
	output logic [15:0] out_cost,
	output logic        in_heap,
	output logic [1:0]  status
);
	localparam int SW = $clog2(NUM_NODES + 1);
	localparam int CB = COST_BITS;
	localparam int EW = SW + CB;
	localparam logic [SW-1:0] ROOT = SW'(1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_NODES);

	cmd_t          cmd_q;
	logic [8:0]    id_q, src_q;
	logic [CB-1:0] ncost_q, cur_cost_q, best_cost_q;
	logic [SW-1:0] count_q, fill_q, slot_q, cur_node_q, best_node_q, best_slot_q;
	logic          best_hit_q;
	logic [8:0]    res_node_q;
	logic [15:0]   res_cost_q;
	logic          res_in_q;
	logic [1:0]    res_st_q;

	logic          h_we, p_we, put;
	logic [SW-1:0] h_waddr, h_raddr, p_waddr, p_raddr, p_wdata, p_rdata;
	logic [EW-1:0] h_wdata, h_rdata;
	logic [SW-1:0] rnode, id_n;
	logic [CB-1:0] rcost;
	logic [SW:0]   left, right, cnt_ext;
	logic          id_ok, src_ok, map_hit, key_lower, up_swap;

	imhq_ram #(.WIDTH(EW), .DEPTH(NUM_NODES + 1)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	imhq_ram #(.WIDTH(SW), .DEPTH(NUM_NODES + 1)) u_pmap (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	assign rnode     = h_rdata[EW-1:CB];
	assign rcost     = h_rdata[CB-1:0];
	assign left      = {slot_q, 1'b0};
	assign right     = {slot_q, 1'b1};
	assign cnt_ext   = {1'b0, count_q};
	assign id_n      = SW'(id_q);
	assign id_ok     = (id_q != 9'd0) && (32'(id_q) <= 32'(NUM_NODES));
	assign src_ok    = (src_q != 9'd0) && (32'(src_q) <= 32'(NUM_NODES));
	assign map_hit   = (p_rdata != '0) && (p_rdata <= count_q);
	assign key_lower = ncost_q < rcost;
	assign up_swap   = cur_cost_q < rcost;

	always_comb begin
		stat.cmd       = cmd_q;
		stat.empty     = (count_q == '0);
		stat.bad_id    = !id_ok;
		stat.fill_last = (fill_q == LAST_SLOT);
		stat.src_ok    = src_ok;
		stat.at_root   = (slot_q == ROOT);
		stat.up_swap   = up_swap;
		stat.has_left  = (left <= cnt_ext);
		stat.has_right = (right <= cnt_ext);
		stat.best_hit  = best_hit_q;
		stat.map_hit   = map_hit;
		stat.key_lower = key_lower;
	end

	// RAM ports; "put" parks the sifting entry at the current slot
	always_comb begin
		put     = 1'b0;
		h_we    = 1'b0;
		h_waddr = slot_q;
		h_wdata = {cur_node_q, cur_cost_q};
		h_raddr = ROOT;
		p_we    = 1'b0;
		p_waddr = cur_node_q;
		p_wdata = slot_q;
		p_raddr = id_n;
		case (ctl.op)
			OP_FILL: begin
				h_we    = 1'b1;
				h_waddr = fill_q;
				h_wdata = {fill_q, (32'(fill_q) == 32'(src_q)) ? {CB{1'b0}} : {CB{1'b1}}};
				p_we    = 1'b1;
				p_waddr = fill_q;
				p_wdata = fill_q;
			end
			OP_SU_CHK: begin
				h_raddr = slot_q >> 1;
				put     = (slot_q == ROOT);
			end
			OP_SU_CMP: begin
				if (up_swap) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					p_we    = 1'b1;
					p_waddr = rnode;
				end else begin
					put = 1'b1;
				end
			end
			OP_SD_CHK: begin
				h_raddr = left[SW-1:0];
				put     = !(left <= cnt_ext);
			end
			OP_SD_L: h_raddr = right[SW-1:0];
			OP_SD_MOVE: begin
				if (best_hit_q) begin
					h_we    = 1'b1;
					h_wdata = {best_node_q, best_cost_q};
					p_we    = 1'b1;
					p_waddr = best_node_q;
				end else begin
					put = 1'b1;
				end
			end
			OP_EX_ROOT: h_raddr = count_q;
			OP_EX_LAST: begin
				p_we    = 1'b1;
				p_waddr = best_node_q;
				p_wdata = '0;
			end
			OP_MAP_CHK: h_raddr = p_rdata;
			default: ;
		endcase
		if (put) begin
			h_we = 1'b1;
			p_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			src_q   <= 9'd1;
		end else begin
			if (cfg_we) begin
				src_q <= cfg_wdata;
			end
			if (ctl.op == OP_FILL && fill_q == LAST_SLOT) begin
				count_q <= LAST_SLOT;
			end else if (ctl.op == OP_EX_LAST) begin
				count_q <= count_q - SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				cmd_q   <= cmd_t'(cmd);
				id_q    <= node_id;
				ncost_q <= CB'(new_cost);
			end
			OP_DISPATCH: begin
				fill_q     <= ROOT;
				res_node_q <= '0;
				res_cost_q <= '0;
				res_in_q   <= 1'b0;
				case (cmd_q)
					CMD_INIT:    res_st_q <= ST_OK;
					CMD_EXTRACT: res_st_q <= ST_EMPTY;
					default: begin
						if (!id_ok) begin
							res_st_q <= ST_REJECT;
						end else begin
							res_node_q <= id_q;
							res_st_q   <= ST_ABSENT;
						end
					end
				endcase
			end
			OP_FILL: fill_q <= fill_q + SW'(1);
			OP_SEED: begin
				slot_q     <= SW'(src_q);
				cur_node_q <= SW'(src_q);
				cur_cost_q <= '0;
			end
			OP_SU_CMP: begin
				if (up_swap) begin
					slot_q <= slot_q >> 1;
				end
			end
			OP_SD_L: begin
				best_node_q <= rnode;
				best_cost_q <= rcost;
				best_slot_q <= left[SW-1:0];
				best_hit_q  <= rcost < cur_cost_q;
			end
			OP_SD_R: begin
				if (rcost < (best_hit_q ? best_cost_q : cur_cost_q)) begin
					best_node_q <= rnode;
					best_cost_q <= rcost;
					best_slot_q <= right[SW-1:0];
					best_hit_q  <= 1'b1;
				end
			end
			OP_SD_MOVE: begin
				if (best_hit_q) begin
					slot_q <= best_slot_q;
				end
			end
			OP_EX_ROOT: begin
				best_node_q <= rnode;
				res_node_q  <= 9'(rnode);
				res_cost_q  <= 16'(rcost);
				res_in_q    <= 1'b0;
				res_st_q    <= ST_OK;
			end
			OP_EX_LAST: begin
				cur_node_q <= rnode;
				cur_cost_q <= rcost;
				slot_q     <= ROOT;
			end
			OP_MAP_CHK: slot_q <= p_rdata;
			OP_KEY_CHK: begin
				res_in_q <= 1'b1;
				if (cmd_q == CMD_DECREASE && key_lower) begin
					cur_node_q <= id_n;
					cur_cost_q <= ncost_q;
					res_cost_q <= 16'(ncost_q);
					res_st_q   <= ST_OK;
				end else begin
					res_cost_q <= 16'(rcost);
					res_st_q   <= (cmd_q == CMD_DECREASE) ? ST_REJECT : ST_OK;
				end
			end
			OP_OUT: begin
				out_node <= res_node_q;
				out_cost <= res_cost_q;
				in_heap  <= res_in_q;
				status   <= res_st_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/imhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhq_ctrl: command sequencer
// Walks fill, sift-up, sift-down and lookup sequences; owns the handshakes.
// ----------------------------------------------------------------------------
module imhq_ctrl import imhq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output ctl_t  ctl,
	input  stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_FILL, S_SEED, S_SU_CHK, S_SU_CMP, S_SD_CHK,
		S_SD_L, S_SD_R, S_SD_MOVE, S_EX_ROOT, S_EX_LAST, S_MAP_CHK,
		S_KEY_CHK, S_DONE
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		case (state_q)
			S_IDLE:     ctl.op = in_valid ? OP_LOAD : OP_NOP;
			S_DISPATCH: ctl.op = OP_DISPATCH;
			S_FILL:     ctl.op = OP_FILL;
			S_SEED:     ctl.op = OP_SEED;
			S_SU_CHK:   ctl.op = OP_SU_CHK;
			S_SU_CMP:   ctl.op = OP_SU_CMP;
			S_SD_CHK:   ctl.op = OP_SD_CHK;
			S_SD_L:     ctl.op = OP_SD_L;
			S_SD_R:     ctl.op = OP_SD_R;
			S_SD_MOVE:  ctl.op = OP_SD_MOVE;
			S_EX_ROOT:  ctl.op = OP_EX_ROOT;
			S_EX_LAST:  ctl.op = OP_EX_LAST;
			S_MAP_CHK:  ctl.op = OP_MAP_CHK;
			S_KEY_CHK:  ctl.op = OP_KEY_CHK;
			S_DONE:     ctl.op = out_free ? OP_OUT : OP_NOP;
			default:    ctl.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (stat.cmd)
						CMD_INIT:    state_q <= S_FILL;
						CMD_EXTRACT: state_q <= stat.empty ? S_DONE : S_EX_ROOT;
						default:     state_q <= (stat.bad_id || stat.empty) ? S_DONE : S_MAP_CHK;
					endcase
				end
				S_FILL: begin
					if (stat.fill_last) begin
						state_q <= S_SEED;
					end
				end
				S_SEED:    state_q <= stat.src_ok ? S_SU_CHK : S_DONE;
				S_SU_CHK:  state_q <= stat.at_root ? S_DONE : S_SU_CMP;
				S_SU_CMP:  state_q <= stat.up_swap ? S_SU_CHK : S_DONE;
				S_SD_CHK:  state_q <= stat.has_left ? S_SD_L : S_DONE;
				S_SD_L:    state_q <= stat.has_right ? S_SD_R : S_SD_MOVE;
				S_SD_R:    state_q <= S_SD_MOVE;
				S_SD_MOVE: state_q <= stat.best_hit ? S_SD_CHK : S_DONE;
				S_EX_ROOT: state_q <= S_EX_LAST;
				S_EX_LAST: state_q <= S_SD_CHK;
				S_MAP_CHK: state_q <= stat.map_hit ? S_KEY_CHK : S_DONE;
				S_KEY_CHK: begin
					state_q <= (stat.cmd == CMD_DECREASE && stat.key_lower) ? S_SU_CHK : S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/indexed_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap with decrease-cost
// Lookup reads the position map, then the heap entry; decrease then climbs
// level by level; extract takes the root and sifts the last entry down from
// the root level by level; init fills every slot and sifts the source up.
// One command in flight at a time; the heap RAM has a single read port.
// Reset clears count, source (to 1) and handshakes; RAMs take no clear pass.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue import imhq_pkg::*; #(
	parameter int NUM_NODES = 256,
	parameter int COST_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	imhq_in_if.sink    in_ch,
	imhq_out_if.source out_ch
);
	// Controller/datapath link: one datapath op per cycle, flags back.
	ctl_t  ctl;
	stat_t stat;

	// Sequencer. in_ch.ready is high only while no command is being worked on;
	// a finished result sits in the output register and the next command can
	// already be taken while it waits for its transfer.
	imhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	// Datapath. The position map is not cleared at reset: while the heap count is
	// zero no map entry is consulted, and init rewrites every entry before the
	// count becomes nonzero, so stale contents are never observed.
	imhq_dp #(
		.NUM_NODES (NUM_NODES),
		.COST_BITS (COST_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (in_ch.cmd),
		.node_id   (in_ch.node_id),
		.new_cost  (in_ch.new_cost),
		.out_node  (out_ch.out_node),
		.out_cost  (out_ch.out_cost),
		.in_heap   (out_ch.in_heap),
		.status    (out_ch.status)
	);

`ifndef ASSERT_OFF
	// a transfer in closes the input until the command finishes
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input reopened right after a transfer");

	// an empty-heap result never names a node
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_EMPTY |-> out_ch.out_node == 9'd0 && !out_ch.in_heap)
		else $error("empty result carries a node");

	// a queued node in a result is always a real node id
	a_queued_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.in_heap |-> out_ch.out_node != 9'd0)
		else $error("queued result with node 0");
`endif
endmodule
